// File: design/qkd_pkg.sv
// shared types, event codes and the detent phase table of the knob decoder
package qkd_pkg;

  // event kinds
  localparam logic [1:0] KIND_LINE_A = 2'd0;
  localparam logic [1:0] KIND_LINE_B = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;
  localparam logic [1:0] KIND_POLL   = 2'd3;

  // detent phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_A_DN   = 3'd1;
  localparam logic [2:0] PH_B_DN   = 3'd2;
  localparam logic [2:0] PH_AB_DN  = 3'd3;
  localparam logic [2:0] PH_BA_DN  = 3'd4;
  localparam logic [2:0] PH_AB_AUP = 3'd5;
  localparam logic [2:0] PH_BA_BUP = 3'd6;
  localparam logic [2:0] PH_SPARE  = 3'd7;

  // click step codes, two's complement
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_FWD  = 2'sb01;
  localparam logic signed [1:0] STEP_BACK = 2'sb11;

  // lockout length after reset, in timer ticks
  localparam logic [15:0] LOCKOUT_RESET = 16'd26;

  // one registered request
  typedef struct packed {
    logic [1:0]  kind;
    logic        channel;
    logic        pin_level;
    logic [15:0] now;
  } qkd_evt_t;

  // next phase after an edge on line A or line B
  function automatic logic [2:0] next_phase(input logic line_b, input logic [2:0] cur,
                                            input logic lvl);
    logic [2:0] nxt;
    nxt = cur;
    if (!line_b) begin
      unique case (cur)
        PH_IDLE:   nxt = lvl ? PH_IDLE   : PH_A_DN;
        PH_A_DN:   nxt = lvl ? PH_IDLE   : PH_A_DN;
        PH_B_DN:   nxt = lvl ? PH_B_DN   : PH_BA_DN;
        PH_AB_DN:  nxt = lvl ? PH_AB_AUP : PH_AB_DN;
        PH_BA_DN:  nxt = lvl ? PH_B_DN   : PH_BA_DN;
        PH_AB_AUP: nxt = lvl ? PH_AB_AUP : PH_AB_DN;
        PH_BA_BUP: nxt = lvl ? PH_IDLE   : PH_BA_BUP;
        default:   nxt = cur;
      endcase
    end else begin
      unique case (cur)
        PH_IDLE:   nxt = lvl ? PH_IDLE   : PH_B_DN;
        PH_A_DN:   nxt = lvl ? PH_A_DN   : PH_AB_DN;
        PH_B_DN:   nxt = lvl ? PH_IDLE   : PH_B_DN;
        PH_AB_DN:  nxt = lvl ? PH_A_DN   : PH_AB_DN;
        PH_BA_DN:  nxt = lvl ? PH_BA_BUP : PH_BA_DN;
        PH_AB_AUP: nxt = lvl ? PH_IDLE   : PH_AB_AUP;
        PH_BA_BUP: nxt = lvl ? PH_BA_BUP : PH_BA_DN;
        default:   nxt = cur;
      endcase
    end
    return nxt;
  endfunction

endpackage

// File: design/qkd_phase.sv
// per-knob detent phase tracking and click step decode
module qkd_phase (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  qkd_pkg::qkd_evt_t evt_i,
  output logic signed [1:0] step_o
);
  import qkd_pkg::*;

  logic [2:0] phase_q [2];
  logic [2:0] phase_d [2];
  logic [2:0] cur;
  logic       is_line;

  assign is_line = (evt_i.kind == KIND_LINE_A) || (evt_i.kind == KIND_LINE_B);
  assign cur     = phase_q[evt_i.channel];

  // completed detent detection
  always_comb begin
    step_o = STEP_NONE;
    if (evt_i.pin_level) begin
      if ((evt_i.kind == KIND_LINE_A) && (cur == PH_BA_BUP)) begin
        step_o = STEP_BACK;
      end else if ((evt_i.kind == KIND_LINE_B) && (cur == PH_AB_AUP)) begin
        step_o = STEP_FWD;
      end
    end
  end

  // table step for the addressed knob
  always_comb begin
    phase_d[0] = phase_q[0];
    phase_d[1] = phase_q[1];
    if (fire_i && is_line) begin
      phase_d[evt_i.channel] = next_phase(evt_i.kind[0], cur, evt_i.pin_level);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q[0] <= PH_IDLE;
      phase_q[1] <= PH_IDLE;
    end else begin
      phase_q[0] <= phase_d[0];
      phase_q[1] <= phase_d[1];
    end
  end

endmodule

// File: design/qkd_lock.sv
// button press lockout: lock on counted press, release on poll after timeout
module qkd_lock (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  qkd_pkg::qkd_evt_t evt_i,
  input  logic [15:0]       lockout_i,
  output logic              pressed_o,
  output logic [1:0]        released_o
);
  import qkd_pkg::*;

  logic [1:0]  locked_q;
  logic [1:0]  locked_d;
  logic [15:0] start_q [2];
  logic [15:0] start_d [2];
  logic [15:0] diff [2];

  // press counts only on an unlocked button
  assign pressed_o = (evt_i.kind == KIND_BUTTON) && !locked_q[evt_i.channel];

  // wrapping elapsed time per button, checked on poll
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      diff[c]       = evt_i.now - start_q[c];
      released_o[c] = (evt_i.kind == KIND_POLL) && locked_q[c] && (diff[c] > lockout_i);
    end
  end

  // lock state update
  always_comb begin
    locked_d   = locked_q;
    start_d[0] = start_q[0];
    start_d[1] = start_q[1];
    if (fire_i) begin
      if (pressed_o) begin
        locked_d[evt_i.channel] = 1'b1;
        start_d[evt_i.channel]  = evt_i.now;
      end
      locked_d = locked_d & ~released_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= '0;
    end else begin
      locked_q <= locked_d;
    end
  end

  // start stamps only matter while locked
  always_ff @(posedge clk_i) begin
    start_q[0] <= start_d[0];
    start_q[1] <= start_d[1];
  end

endmodule

// File: design/quadrature_knob_decoder.sv
// two-knob quadrature decoder with button lockout, top level
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o   | kind_i, channel_i, pin_level_i, now_i
//  out     | out_valid_o / out_ready_i | out_channel_o, click_step_o,
//          |                           | press_counted_o, release_mask_o
//  cfg     | cfg_valid_i / cfg_ready_o | lockout_ticks_i
//
// One request per cycle while the result side takes results: it is registered,
// then decoded against the knob and lock state into the result register.
// Reset clears both knob phases, both button locks and sets lockout to 26.
// A stalled result holds in its register while the input register keeps
// accepting until it is full too; config writes are always taken.
module quadrature_knob_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic              channel_i,
  input  logic              pin_level_i,
  input  logic [15:0]       now_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_channel_o,
  output logic signed [1:0] click_step_o,
  output logic              press_counted_o,
  output logic [1:0]        release_mask_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       lockout_ticks_i
);
  import qkd_pkg::*;

  logic              s1_valid_q;
  logic              s1_valid_d;
  qkd_evt_t          s1_evt_q;
  logic              s1_adv;
  logic              in_acc;
  logic              out_valid_q;
  logic              out_valid_d;
  logic [15:0]       lockout_q;
  logic signed [1:0] step;
  logic              pressed;
  logic [1:0]        released;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LOCKOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lockout_q <= lockout_ticks_i;
    end
  end

  // handshake control
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_evt_q.kind      <= kind_i;
      s1_evt_q.channel   <= channel_i;
      s1_evt_q.pin_level <= pin_level_i;
      s1_evt_q.now       <= now_i;
    end
  end

  qkd_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .evt_i  (s1_evt_q),
    .step_o (step)
  );

  qkd_lock u_lock (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_adv),
    .evt_i      (s1_evt_q),
    .lockout_i  (lockout_q),
    .pressed_o  (pressed),
    .released_o (released)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_channel_o   <= s1_evt_q.channel;
      click_step_o    <= step;
      press_counted_o <= pressed;
      release_mask_o  <= released;
    end
  end

  // a result carries at most one kind of news
  a_one_news: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (press_counted_o || (release_mask_o != 2'b00)) |->
      (click_step_o == STEP_NONE))
    else $error("click step reported together with a button result");

  // step code two is never produced
  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (click_step_o != 2'sb10))
    else $error("invalid click step code");

  // an empty input register always takes a request
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled while input register empty");

  // a poll never reports a press
  a_poll_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_evt_q.kind == KIND_POLL) |=> !press_counted_o)
    else $error("press counted on a poll");

endmodule

// File: sim/testbench.sv
// self-checking testbench for the two-knob quadrature decoder with button lockout
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qkd_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // random requests per lockout setting
  localparam int ITEMS_PER_PHASE = 150;
  // cycles a request takes from input to result register
  localparam int PIPE_DEPTH = 2;

  // one expected decoder result
  typedef struct {
    logic              knob;
    logic signed [1:0] step;
    logic              pressed;
    logic [1:0]        released;
  } knob_result_t;

  // predictor of the knob state plus the queue of results still owed
  class knob_scoreboard;
    logic [2:0]   detent_phase [2];
    logic         locked [2];
    logic [15:0]  locked_at [2];
    logic [15:0]  lockout;
    knob_result_t owed_results [$];
    int mismatches;
    int fwd_clicks;
    int back_clicks;
    int presses;
    int releases;

    function new();
      for (int k = 0; k < 2; k++) begin
        detent_phase[k] = PH_IDLE;
        locked[k] = 1'b0;
        locked_at[k] = '0;
      end
      lockout = LOCKOUT_RESET;
      mismatches = 0;
      fwd_clicks = 0;
      back_clicks = 0;
      presses = 0;
      releases = 0;
    endfunction

    function void set_lockout(logic [15:0] ticks);
      lockout = ticks;
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // detent phase after an edge, grouped by which line moved and where it went
    function logic [2:0] advance(logic line_b, logic [2:0] cur, logic lvl);
      logic [2:0] nxt;
      nxt = cur;
      case ({line_b, lvl})
        // line A fell
        2'b00: begin
          case (cur)
            PH_IDLE, PH_A_DN:    nxt = PH_A_DN;
            PH_B_DN, PH_BA_DN:   nxt = PH_BA_DN;
            PH_AB_DN, PH_AB_AUP: nxt = PH_AB_DN;
            PH_BA_BUP:           nxt = PH_BA_BUP;
            default:             nxt = cur;
          endcase
        end
        // line A rose
        2'b01: begin
          case (cur)
            PH_IDLE, PH_A_DN, PH_BA_BUP: nxt = PH_IDLE;
            PH_B_DN, PH_BA_DN:           nxt = PH_B_DN;
            PH_AB_DN, PH_AB_AUP:         nxt = PH_AB_AUP;
            default:                     nxt = cur;
          endcase
        end
        // line B fell
        2'b10: begin
          case (cur)
            PH_IDLE, PH_B_DN:    nxt = PH_B_DN;
            PH_A_DN, PH_AB_DN:   nxt = PH_AB_DN;
            PH_BA_DN, PH_BA_BUP: nxt = PH_BA_DN;
            PH_AB_AUP:           nxt = PH_AB_AUP;
            default:             nxt = cur;
          endcase
        end
        // line B rose
        default: begin
          case (cur)
            PH_IDLE, PH_B_DN, PH_AB_AUP: nxt = PH_IDLE;
            PH_A_DN, PH_AB_DN:           nxt = PH_A_DN;
            PH_BA_DN, PH_BA_BUP:         nxt = PH_BA_BUP;
            default:                     nxt = cur;
          endcase
        end
      endcase
      return nxt;
    endfunction

    // accepted request: update the model state and queue the result it owes
    function void note_event(logic [1:0] kind, logic knob, logic lvl, logic [15:0] stamp);
      knob_result_t res;
      logic [15:0] held;
      res.knob = knob;
      res.step = STEP_NONE;
      res.pressed = 1'b0;
      res.released = 2'b00;
      case (kind)
        KIND_LINE_A, KIND_LINE_B: begin
          if (kind == KIND_LINE_A && detent_phase[knob] == PH_BA_BUP && lvl) begin
            res.step = STEP_BACK;
            back_clicks++;
          end
          if (kind == KIND_LINE_B && detent_phase[knob] == PH_AB_AUP && lvl) begin
            res.step = STEP_FWD;
            fwd_clicks++;
          end
          detent_phase[knob] = advance(kind == KIND_LINE_B, detent_phase[knob], lvl);
        end
        KIND_BUTTON: begin
          if (!locked[knob]) begin
            res.pressed = 1'b1;
            locked[knob] = 1'b1;
            locked_at[knob] = stamp;
            presses++;
          end
        end
        default: begin
          // poll checks both buttons against the wrapping timer difference
          for (int k = 0; k < 2; k++) begin
            held = stamp - locked_at[k];
            if (locked[k] && held > lockout) begin
              locked[k] = 1'b0;
              res.released[k] = 1'b1;
              releases++;
            end
          end
        end
      endcase
      owed_results.push_back(res);
    endfunction

    // accepted result: compare against the oldest owed one
    function void check_result(logic knob, logic signed [1:0] step, logic pressed,
                               logic [1:0] released);
      knob_result_t exp_res;
      if (owed_results.size() == 0) begin
        $error("unexpected result: out_channel=%0d click_step=%0d", knob, step);
        mismatches++;
        return;
      end
      exp_res = owed_results.pop_front();
      if (knob !== exp_res.knob) begin
        $error("out_channel: expected %0d, got %0d", exp_res.knob, knob);
        mismatches++;
      end
      if (step !== exp_res.step) begin
        $error("click_step: expected %0d, got %0d", exp_res.step, step);
        mismatches++;
      end
      if (pressed !== exp_res.pressed) begin
        $error("press_counted: expected %0d, got %0d", exp_res.pressed, pressed);
        mismatches++;
      end
      if (released !== exp_res.released) begin
        $error("release_mask: expected %0d, got %0d", exp_res.released, released);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i = KIND_LINE_A;
  logic              channel_i = 1'b0;
  logic              pin_level_i = 1'b0;
  logic [15:0]       now_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              out_channel_o;
  logic signed [1:0] click_step_o;
  logic              press_counted_o;
  logic [1:0]        release_mask_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [15:0]       lockout_ticks_i = '0;

  knob_scoreboard sb = new();
  logic        steady = 1'b0;
  logic [15:0] timer_now = '0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          settings_run = 1;

  quadrature_knob_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .channel_i       (channel_i),
    .pin_level_i     (pin_level_i),
    .now_i           (now_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_channel_o   (out_channel_o),
    .click_step_o    (click_step_o),
    .press_counted_o (press_counted_o),
    .release_mask_o  (release_mask_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .lockout_ticks_i (lockout_ticks_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 34);
    end
  end

  // handshake monitor and hang watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_channel_o, click_step_o, press_counted_o, release_mask_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_event(kind_i, channel_i, pin_level_i, now_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_lockout(lockout_ticks_i);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one request, with random idle cycles ahead of it unless steady; called and returns at a falling edge
  task automatic send_event(input logic [1:0] kind, input logic knob, input logic lvl,
                            input logic [15:0] stamp);
    if (!steady) begin
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    channel_i   <= knob;
    pin_level_i <= lvl;
    now_i       <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // hold requests until every owed result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic write_lockout(input logic [15:0] ticks);
    wait_drained();
    repeat (PIPE_DEPTH + 1) @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    lockout_ticks_i <= ticks;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // one detent of edges in order, with occasional contact bounce or an early stop
  task automatic turn_knob(input logic knob, input logic fwd);
    logic [1:0] lead;
    logic [1:0] trail;
    logic [1:0] line;
    logic       lvl;
    lead  = fwd ? KIND_LINE_A : KIND_LINE_B;
    trail = fwd ? KIND_LINE_B : KIND_LINE_A;
    for (int e = 0; e < 4; e++) begin
      line = (e % 2 == 0) ? lead : trail;
      lvl  = (e >= 2);
      send_event(line, knob, lvl, 16'($urandom));
      if ($urandom_range(99) < 15) begin
        send_event(line, knob, !lvl, 16'($urandom));
        send_event(line, knob, lvl, 16'($urandom));
      end
      if ($urandom_range(99) < 8) break;
    end
  endtask

  // timer moves on by small steps, now and then by a large jump
  task automatic tick_timer();
    if ($urandom_range(99) < 10) begin
      timer_now = 16'($urandom);
    end else begin
      timer_now = timer_now + 16'($urandom_range(0, 40));
    end
  endtask

  // random traffic: mostly well-formed rotations, presses and polls, some noise
  task automatic random_traffic(input int count, input int pause_at);
    int pick;
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if (pause_at > 0 && items_sent - start >= pause_at) begin
        wait_drained();
        pause_at = 0;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_event(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   16'($urandom));
      end else if (pick < 55) begin
        turn_knob(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 75) begin
        tick_timer();
        send_event(KIND_BUTTON, 1'($urandom_range(1)), 1'($urandom_range(1)), timer_now);
      end else begin
        tick_timer();
        send_event(KIND_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)), timer_now);
      end
    end
  endtask

  initial begin
    logic [15:0] lockout_plan [5];
    lockout_plan[0] = 16'd0;
    lockout_plan[1] = 16'hFFFF;
    lockout_plan[2] = 16'($urandom_range(1, 300));
    lockout_plan[3] = 16'($urandom);
    lockout_plan[4] = LOCKOUT_RESET;

    // reset
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full forward detent on the bottom knob, full backward detent on the top knob
    send_event(KIND_LINE_A, 1'b0, 1'b0, 16'h0000);
    send_event(KIND_LINE_B, 1'b0, 1'b0, 16'hFFFF);
    send_event(KIND_LINE_A, 1'b0, 1'b1, 16'h0000);
    send_event(KIND_LINE_B, 1'b0, 1'b1, 16'hFFFF);
    send_event(KIND_LINE_B, 1'b1, 1'b0, 16'h1234);
    send_event(KIND_LINE_A, 1'b1, 1'b0, 16'h1234);
    send_event(KIND_LINE_B, 1'b1, 1'b1, 16'h1234);
    send_event(KIND_LINE_A, 1'b1, 1'b1, 16'h1234);
    // levels that do not fit the phase, and a step back
    send_event(KIND_LINE_A, 1'b0, 1'b1, 16'h0000);
    send_event(KIND_LINE_B, 1'b0, 1'b1, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b0, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b0, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b1, 16'h0000);
    // press, press while locked, poll right at the limit, poll one tick past it
    send_event(KIND_BUTTON, 1'b0, 1'b1, 16'hFFF0);
    send_event(KIND_BUTTON, 1'b0, 1'b0, 16'h0005);
    send_event(KIND_POLL, 1'b1, 1'b1, 16'h000A);
    send_event(KIND_POLL, 1'b0, 1'b0, 16'h000B);
    // both buttons released by one poll across the timer wrap
    send_event(KIND_BUTTON, 1'b1, 1'b0, 16'hFFFF);
    send_event(KIND_POLL, 1'b1, 1'b0, 16'hFFFF);
    send_event(KIND_BUTTON, 1'b0, 1'b1, 16'h0000);
    send_event(KIND_POLL, 1'b0, 1'b1, 16'd100);
    // reversal in the middle of a forward detent on the top knob
    send_event(KIND_LINE_A, 1'b1, 1'b0, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b0, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b1, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b0, 16'h0000);
    send_event(KIND_LINE_A, 1'b1, 1'b1, 16'h0000);
    send_event(KIND_LINE_B, 1'b1, 1'b1, 16'h0000);

    // random traffic at the reset lockout, then at each written setting
    random_traffic(ITEMS_PER_PHASE, 0);
    for (int p = 0; p < 5; p++) begin
      write_lockout(lockout_plan[p]);
      steady = (p == 2);
      random_traffic(ITEMS_PER_PHASE, (p == 1) ? ITEMS_PER_PHASE / 2 : 0);
      steady = 1'b0;
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);

    $display("covered %0d requests over %0d lockout settings", items_sent, settings_run);
    $display("%0d forward and %0d backward detents, %0d counted presses, %0d releases",
             sb.fwd_clicks, sb.back_clicks, sb.presses, sb.releases);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.outstanding());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
